// ===== sv/drp_pkg.sv =====
// drp_pkg: word types, result kinds, status codes and constants of the
// delimited record field parser. No dependencies.
package drp_pkg;

  // Input word: one line byte or an end-of-line marker.
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         field_index;
    logic [7:0]         out_byte;
    logic signed [31:0] int_value;
    logic [2:0]         status;
    logic               last;
  } out_word_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_STR_BYTE = 2'd0;
  localparam kind_t KIND_STR_END  = 2'd1;
  localparam kind_t KIND_INT_VAL  = 2'd2;
  localparam kind_t KIND_STATUS   = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NO_DIGITS = 3'd1;
  localparam status_t ST_RANGE     = 3'd2;
  localparam status_t ST_TRAILING  = 3'd3;
  localparam status_t ST_TOO_MANY  = 3'd4;
  localparam status_t ST_TOO_FEW   = 3'd5;

  localparam logic       CMD_BYTE = 1'b0;
  localparam logic       CMD_EOL  = 1'b1;

  localparam logic [7:0] DELIM_CH = 8'h7C;
  localparam logic [7:0] PLUS_CH  = 8'h2B;
  localparam logic [7:0] MINUS_CH = 8'h2D;
  localparam logic [7:0] ZERO_CH  = 8'h30;
  localparam logic [7:0] NINE_CH  = 8'h39;
  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] TAB_CH   = 8'h09;
  localparam logic [7:0] CR_CH    = 8'h0D;

  // Register addresses (byte address bit 2 selects the register).
  localparam logic REG_FIELD_COUNT = 1'b0;
  localparam logic REG_INT_MASK    = 1'b1;

  // Result queue: four words, room for two pushes per cycle.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  // Push request from the parser into the result queue.
  typedef struct packed {
    logic [1:0] n;      // words to push this cycle, 0..2
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

endpackage

// ===== sv/drp_fifo.sv =====
// drp_fifo: four-word result queue, up to two pushes and one pop per cycle.
// Depends on drp_pkg.
module drp_fifo import drp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  input  logic      pop,
  output logic      full2,     // fewer than two free words
  output logic      valid,
  output out_word_t head
);

  out_word_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]       wp_r, rp_r;
  logic [FIFO_CW-1:0]       cnt_r, cnt_nxt;
  logic                     do_pop;

  assign valid  = (cnt_r != '0);
  assign head   = mem_r[rp_r];
  assign do_pop = pop && valid;
  assign full2  = (cnt_r > FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    cnt_nxt = cnt_r + FIFO_CW'(push.n) - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.w0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp_r + FIFO_AW'(1)] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FIFO_AW'(push.n);
      rp_r  <= rp_r + FIFO_AW'(do_pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/delimited_record_field_parser.sv =====
// delimited_record_field_parser: splits '|' separated lines into string bytes,
// field ends, int32 values and one status word per line.
// Depends on drp_pkg and drp_fifo.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_word): one word per line byte
//    (cmd = 0) and a closing word with cmd = 1 at end of line.
//  - Output channel (out_valid/out_stall/out_word): string bytes, string
//    field ends, integer values and one status word (last = 1) per line.
//  - APB-style config port: field_count at 0x0, int_field_mask at 0x4.
//    Write only while the block is idle.
// Timing:
//  - One input word per cycle while in_stall is low. Parser state lives in registers; each byte
//    is one combinational update (one multiply-by-ten accumulate and compare).
//  - Results land in a 4-word queue and show on the output in the cycle after
//    the input word is taken when the queue is empty. An end-of-line word
//    yields up to two results, which leave the queue one at a time.
//  - in_stall rises when the queue has fewer than two free words: under
//    out_stall, or when end-of-line words with two results come back to back.
// Reset: queue empties, field_count = 1, mask = 0, parser at field 0.
module delimited_record_field_parser import drp_pkg::*; #(
  parameter int unsigned MAX_FIELDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned CF_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  // integer phase: one-hot
  typedef enum logic [2:0] {
    PH_WS     = 3'b001,
    PH_SIGN   = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  // ---------------- configuration registers ----------------
  logic [5:0]  field_count_r;
  logic [31:0] int_mask_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_count_r <= 6'd1;
      int_mask_r    <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_FIELD_COUNT) begin
        field_count_r <= cfg_pwdata[5:0];
      end else begin
        int_mask_r <= cfg_pwdata;
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_INT_MASK) begin
      cfg_prdata = int_mask_r;
    end else begin
      cfg_prdata = {26'd0, field_count_r};
    end
  end

  // effective field count: 0 acts as 1, clamp to MAX_FIELDS
  logic [6:0] eff_cnt;
  always_comb begin
    if (field_count_r == 6'd0) begin
      eff_cnt = 7'd1;
    end else if (7'(field_count_r) > 7'(MAX_FIELDS)) begin
      eff_cnt = 7'(MAX_FIELDS);
    end else begin
      eff_cnt = 7'(field_count_r);
    end
  end

  // ---------------- parser state ----------------
  logic [CF_W-1:0] cur_r,   cur_nxt;
  phase_t          phase_r, phase_nxt;
  logic            neg_r,   neg_nxt;
  logic [31:0]     mag_r,   mag_nxt;
  logic            ovf_r,   ovf_nxt;
  status_t         err_r,   err_nxt;

  logic      accept;
  push_t     push;
  logic      fifo_full2;

  assign in_stall = fifo_full2;
  assign accept   = in_valid && !in_stall;

  // decode helpers
  logic [6:0]  cur7;
  logic        is_int;
  logic        is_digit;
  logic        is_space;
  logic [35:0] acc;         // mag * 10 + digit
  logic [35:0] limit;
  logic        last_field;  // current field is the last one expected
  out_word_t   blank;

  always_comb begin
    cur7       = 7'(cur_r);
    is_int     = (cur7 < 7'd32) && int_mask_r[cur7[4:0]];
    is_digit   = (in_word.ch >= ZERO_CH) && (in_word.ch <= NINE_CH);
    is_space   = (in_word.ch == SPACE_CH) ||
                 ((in_word.ch >= TAB_CH) && (in_word.ch <= CR_CH));
    acc        = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} +
                 36'({4'd0, in_word.ch[3:0]} - 8'd0);
    limit      = 36'h07FFFFFFF + 36'(neg_r);
    last_field = (cur7 + 7'd1) >= eff_cnt;
    blank             = '0;
    blank.field_index = cur7[4:0];
  end

  // one word of work: next state and up to two results
  always_comb begin
    out_word_t fres;     // result of closing the field, if any
    logic      fhas;
    status_t   ferr;

    cur_nxt   = cur_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    err_nxt   = err_r;
    push      = '0;
    push.w0   = blank;
    push.w1   = blank;

    // field close
    fres = blank;
    fhas = 1'b0;
    ferr = ST_OK;
    if (!is_int) begin
      fres.kind = KIND_STR_END;
      fhas      = 1'b1;
    end else if (phase_r != PH_DIGITS) begin
      ferr = ST_NO_DIGITS;
    end else if (ovf_r) begin
      ferr = ST_RANGE;
    end else begin
      fres.kind      = KIND_INT_VAL;
      fres.int_value = neg_r ? (32'd0 - mag_r) : mag_r;
      fhas           = 1'b1;
    end

    if (accept) begin
      if (in_word.cmd == CMD_EOL) begin
        status_t st;
        st = err_r;
        if (err_r == ST_OK) begin
          st = ferr;
          if (ferr == ST_OK && (cur7 + 7'd1) != eff_cnt) begin
            st = ST_TOO_FEW;
          end
        end
        if (err_r == ST_OK && fhas) begin
          push.n         = 2'd2;
          push.w0        = fres;
          push.w1.kind   = KIND_STATUS;
          push.w1.status = st;
          push.w1.last   = 1'b1;
        end else begin
          push.n         = 2'd1;
          push.w0.kind   = KIND_STATUS;
          push.w0.status = st;
          push.w0.last   = 1'b1;
        end
        cur_nxt   = '0;
        err_nxt   = ST_OK;
        phase_nxt = PH_WS;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else if (err_r != ST_OK) begin
        // rest of line suppressed
      end else if (in_word.ch == DELIM_CH) begin
        push.n  = fhas ? 2'd1 : 2'd0;
        push.w0 = fres;
        if (ferr != ST_OK) begin
          err_nxt = ferr;
        end else if (last_field) begin
          err_nxt = ST_TOO_MANY;
        end else begin
          cur_nxt   = cur_r + CF_W'(1);
          phase_nxt = PH_WS;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
      end else if (is_int) begin
        if (is_digit) begin
          phase_nxt = PH_DIGITS;
          if (!ovf_r) begin
            if (acc > limit) begin
              ovf_nxt = 1'b1;
            end else begin
              mag_nxt = acc[31:0];
            end
          end
        end else begin
          case (phase_r)
            PH_WS: begin
              if (is_space) begin
                // skip
              end else if (in_word.ch == PLUS_CH || in_word.ch == MINUS_CH) begin
                neg_nxt   = (in_word.ch == MINUS_CH);
                phase_nxt = PH_SIGN;
              end else begin
                err_nxt = ST_NO_DIGITS;
              end
            end
            PH_SIGN:   err_nxt = ST_NO_DIGITS;
            PH_DIGITS: err_nxt = ovf_r ? ST_RANGE : ST_TRAILING;
            default:   err_nxt = ST_NO_DIGITS;
          endcase
        end
      end else begin
        push.n           = 2'd1;
        push.w0.kind     = KIND_STR_BYTE;
        push.w0.out_byte = in_word.ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      phase_r <= PH_WS;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      ovf_r   <= 1'b0;
      err_r   <= ST_OK;
    end else begin
      cur_r   <= cur_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      ovf_r   <= ovf_nxt;
      err_r   <= err_nxt;
    end
  end

  // ---------------- result queue ----------------
  drp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (!out_stall),
    .full2 (fifo_full2),
    .valid (out_valid),
    .head  (out_word)
  );

endmodule
